// ===== hw/rtl/olist_pkg.sv =====
// Types and constants shared by the ordered list core modules.
`timescale 1ns / 1ps
`default_nettype none

package olist_pkg;

  localparam int ListDepth = 16;
  localparam int IdxW      = 4;
  localparam int CountW    = 5;
  localparam int DataW     = 32;

  localparam logic [1:0] FuncInsert = 2'd0;
  localparam logic [1:0] FuncDelete = 2'd1;
  localparam logic [1:0] FuncSearch = 2'd2;

  localparam logic [1:0] StatusOk     = 2'd0;
  localparam logic [1:0] StatusBounds = 2'd1;
  localparam logic [1:0] StatusFull   = 2'd2;

  typedef struct packed {
    logic [1:0]              func;
    logic signed [DataW-1:0] value;
    logic [CountW-1:0]       position;
  } req_t;

  typedef struct packed {
    logic [1:0]              status;
    logic signed [DataW-1:0] removed_value;
    logic                    found;
    logic [IdxW-1:0]         found_position;
    logic [CountW-1:0]       length;
    logic                    empty_res;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic finish;
  } cmd_t;

  typedef enum logic [1:0] {
    StIdle,
    StExec,
    StDone
  } state_e;

endpackage

`default_nettype wire

// ===== hw/rtl/ordered_list_insert_delete_search_core.sv =====
// Top level of the ordered list core with insert, delete and search.
// Each accepted word passes the load, execute and encode steps of the controller
// in order, and the result word is strobed once the encode step has registered it.
// Start is taken only while idle; busy is low again in the cycle of the strobe.
// Reset clears the length and the controller; list entries hold no reset value.
// The receiver cannot stall, so each result is shown for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none

module ordered_list_insert_delete_search_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  olist_pkg::req_t  req_i,
  output logic             result_valid_o,
  output olist_pkg::rsp_t  rsp_o
);
  import olist_pkg::*;

  cmd_t cmd;

  olist_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .cmd_o          (cmd),
    .busy           (busy),
    .result_valid_o (result_valid_o)
  );

  olist_dp u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .req_i  (req_i),
    .rsp_o  (rsp_o)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/olist_ctrl.sv =====
// Controller state machine that sequences each list operation.
`timescale 1ns / 1ps
`default_nettype none

module olist_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output olist_pkg::cmd_t    cmd_o,
  output logic               busy,
  output logic               result_valid_o
);
  import olist_pkg::*;

  state_e state_q, state_d;
  logic   valid_q, valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = StExec;
        end
      end
      StExec: begin
        cmd_o.exec = 1'b1;
        state_d    = StDone;
      end
      StDone: begin
        cmd_o.finish = 1'b1;
        state_d      = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
    valid_d = cmd_o.finish;
  end

  assign busy           = (state_q != StIdle);
  assign result_valid_o = valid_q;

endmodule

`default_nettype wire

// ===== hw/rtl/olist_dp.sv =====
// Datapath holding the list entries, the length and the result word.
`timescale 1ns / 1ps
`default_nettype none

module olist_dp (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  olist_pkg::cmd_t      cmd_i,
  input  olist_pkg::req_t      req_i,
  output olist_pkg::rsp_t      rsp_o
);
  import olist_pkg::*;

  req_t                    op_q;
  logic signed [DataW-1:0] entries_q [ListDepth];
  logic [CountW-1:0]       count_q, count_d;
  logic [ListDepth-1:0]    match_q, match_d;
  logic [1:0]              status_q, status_d;
  logic signed [DataW-1:0] removed_q, removed_d;
  logic                    do_ins, do_del;
  logic [IdxW-1:0]         fpos;
  rsp_t                    rsp_q;

  always_comb begin
    status_d  = StatusOk;
    removed_d = '0;
    match_d   = '0;
    count_d   = count_q;
    do_ins    = 1'b0;
    do_del    = 1'b0;
    case (op_q.func)
      FuncInsert: begin
        if (op_q.position > count_q) begin
          status_d = StatusBounds;
        end else if (count_q == CountW'(ListDepth)) begin
          status_d = StatusFull;
        end else begin
          do_ins  = 1'b1;
          count_d = count_q + CountW'(1);
        end
      end
      FuncDelete: begin
        if (op_q.position >= count_q) begin
          status_d = StatusBounds;
        end else begin
          do_del    = 1'b1;
          removed_d = entries_q[op_q.position[IdxW-1:0]];
          count_d   = count_q - CountW'(1);
        end
      end
      FuncSearch: begin
        for (int i = 0; i < ListDepth; i++) begin
          match_d[i] = (entries_q[i] == op_q.value) && (CountW'(i) < count_q);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q <= req_i;
    end
    if (cmd_i.exec) begin
      match_q   <= match_d;
      status_q  <= status_d;
      removed_q <= removed_d;
      for (int i = 0; i < ListDepth; i++) begin
        if (do_ins) begin
          if (CountW'(i) == op_q.position) begin
            entries_q[i] <= op_q.value;
          end else if ((CountW'(i) > op_q.position) && (i > 0)) begin
            entries_q[i] <= entries_q[(i > 0) ? i - 1 : 0];
          end
        end else if (do_del) begin
          if ((CountW'(i) >= op_q.position) && (i < ListDepth - 1)) begin
            entries_q[i] <= entries_q[(i < ListDepth - 1) ? i + 1 : i];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.exec) begin
      count_q <= count_d;
    end
  end

  always_comb begin
    fpos = '0;
    for (int i = ListDepth - 1; i >= 0; i--) begin
      if (match_q[i]) begin
        fpos = IdxW'(i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      rsp_q.status         <= status_q;
      rsp_q.removed_value  <= removed_q;
      rsp_q.found          <= |match_q;
      rsp_q.found_position <= fpos;
      rsp_q.length         <= count_q;
      rsp_q.empty_res      <= (count_q == '0);
    end
  end

  assign rsp_o = rsp_q;

endmodule

`default_nettype wire

// ===== hw/rtl/olist_chk.sv =====
// Port-level checker for the ordered list core and its bind statement.
`timescale 1ns / 1ps
`default_nettype none

module olist_chk (
  input wire logic            clk_i,
  input wire logic            rst_ni,
  input wire logic            start,
  input wire logic            busy,
  input wire logic            result_valid_o,
  input olist_pkg::rsp_t      rsp_o
);
  import olist_pkg::*;

  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("Core did not go busy after accepting a word.");

  a_fixed_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##3 result_valid_o)
    else $error("Result word did not appear three cycles after acceptance.");

  a_single_pulse : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("Result strobe lasted more than one cycle.");

  a_full_length : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (rsp_o.status == StatusFull)) |-> (rsp_o.length == 5'd16))
    else $error("Full status reported with a list that is not full.");

  a_empty_flag : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (rsp_o.empty_res == (rsp_o.length == 5'd0)))
    else $error("Empty flag disagrees with the reported length.");

endmodule

bind ordered_list_insert_delete_search_core olist_chk u_olist_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .result_valid_o (result_valid_o),
  .rsp_o          (rsp_o)
);

`default_nettype wire
